>>> hw/rtl/complex_arith_unit_assert.svh
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CAU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CAU_ASSERT_NOW(lbl, ante, cons)
`define CAU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/cau_pkg.sv
// shared types, widths and helpers for the complex arithmetic unit
`default_nettype none
package cau_pkg;
    localparam int FRAC_BITS = 16;
    // magnitude numerator, divisor, compare and quotient widths
    localparam int NW = 32 + FRAC_BITS;
    localparam int DW = 64 - FRAC_BITS;
    localparam int CW = DW + 31;
    localparam int QW = 31;
    localparam int DIV_STEPS = QW;

    localparam logic signed [65:0] SAT_MAX = 66'sh7fffffff;
    localparam logic signed [65:0] SAT_MIN = -SAT_MAX - 66'sd1;

    typedef enum logic [2:0] {
        OP_SUM  = 3'd0,
        OP_PROD = 3'd1,
        OP_CONJ = 3'd2,
        OP_NEG  = 3'd3,
        OP_INV  = 3'd4,
        OP_CMP  = 3'd5
    } t_op;

    typedef struct packed {
        logic               valid;
        logic [2:0]         op;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } t_s0;

    typedef struct packed {
        logic               valid;
        logic               is_prod;
        logic               is_inv;
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] dir_re;
        logic signed [31:0] dir_im;
        logic               dir_ok;
    } t_s1;

    typedef struct packed {
        logic               valid;
        logic               use_div;
        logic signed [31:0] dir_re;
        logic signed [31:0] dir_im;
        logic               dir_ok;
        logic [NW-1:0]      rem_re;
        logic [NW-1:0]      rem_im;
        logic [CW-1:0]      dsh;
        logic [QW-1:0]      q_re;
        logic [QW-1:0]      q_im;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
    } t_dv;

    // clamp a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/cau_front.sv
// input register, multipliers and the single-step operations
`default_nettype none
module cau_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_a_re,
    input  wire logic signed [31:0] i_a_im,
    input  wire logic signed [31:0] i_b_re,
    input  wire logic signed [31:0] i_b_im,
    input  wire logic [30:0]        i_epsilon,
    output cau_pkg::t_s1            o_s1
);
    import cau_pkg::*;

    t_s0 r_s0;
    t_s1 r_s1;
    t_s1 n_s1;
    logic signed [31:0] w_m0b;
    logic signed [31:0] w_m1b;
    logic signed [32:0] w_dre;
    logic signed [32:0] w_dim;
    logic [32:0]        w_abs_re;
    logic [32:0]        w_abs_im;

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else begin
            r_s0.valid <= i_start;
        end
        r_s0.op <= i_operation;
        r_s0.ar <= i_a_re;
        r_s0.ai <= i_a_im;
        r_s0.br <= i_b_re;
        r_s0.bi <= i_b_im;
    end

    // invert squares A, product crosses A with B
    assign w_m0b = (r_s0.op == OP_INV) ? r_s0.ar : r_s0.br;
    assign w_m1b = (r_s0.op == OP_INV) ? r_s0.ai : r_s0.bi;

    // exact component differences for compare
    assign w_dre = 33'(r_s0.ar) - 33'(r_s0.br);
    assign w_dim = 33'(r_s0.ai) - 33'(r_s0.bi);
    assign w_abs_re = w_dre[32] ? 33'(-w_dre) : 33'(w_dre);
    assign w_abs_im = w_dim[32] ? 33'(-w_dim) : 33'(w_dim);

    always_comb begin
        n_s1         = '0;
        n_s1.valid   = r_s0.valid;
        n_s1.p0      = r_s0.ar * w_m0b;
        n_s1.p1      = r_s0.ai * w_m1b;
        n_s1.p2      = r_s0.ar * r_s0.bi;
        n_s1.p3      = r_s0.ai * r_s0.br;
        n_s1.ar      = r_s0.ar;
        n_s1.ai      = r_s0.ai;
        n_s1.dir_ok  = 1'b1;
        unique case (r_s0.op)
            OP_SUM: begin
                n_s1.dir_re = sat32(66'(r_s0.ar) + 66'(r_s0.br));
                n_s1.dir_im = sat32(66'(r_s0.ai) + 66'(r_s0.bi));
            end
            OP_PROD: begin
                n_s1.is_prod = 1'b1;
            end
            OP_CONJ: begin
                n_s1.dir_re = r_s0.ar;
                n_s1.dir_im = sat32(-66'(r_s0.ai));
            end
            OP_NEG: begin
                n_s1.dir_re = sat32(-66'(r_s0.ar));
                n_s1.dir_im = sat32(-66'(r_s0.ai));
            end
            OP_INV: begin
                n_s1.is_inv = 1'b1;
            end
            OP_CMP: begin
                n_s1.dir_ok = (w_abs_re < {2'b00, i_epsilon})
                           && (w_abs_im < {2'b00, i_epsilon});
            end
            default: begin
                n_s1.dir_ok = 1'b0;
            end
        endcase
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.is_prod <= n_s1.is_prod;
        r_s1.is_inv  <= n_s1.is_inv;
        r_s1.p0      <= n_s1.p0;
        r_s1.p1      <= n_s1.p1;
        r_s1.p2      <= n_s1.p2;
        r_s1.p3      <= n_s1.p3;
        r_s1.ar      <= n_s1.ar;
        r_s1.ai      <= n_s1.ai;
        r_s1.dir_re  <= n_s1.dir_re;
        r_s1.dir_im  <= n_s1.dir_im;
        r_s1.dir_ok  <= n_s1.dir_ok;
    end

    assign o_s1 = r_s1;
endmodule
`default_nettype wire

>>> hw/rtl/cau_prep.sv
// product rescale, squared magnitude and divider setup
`default_nettype none
module cau_prep (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  cau_pkg::t_s1      i_s1,
    input  wire logic [30:0]  i_epsilon,
    output cau_pkg::t_dv      o_dv
);
    import cau_pkg::*;

    t_dv r_dv;
    t_dv n_dv;
    logic signed [65:0] w_sre;
    logic signed [65:0] w_sim;
    logic [63:0]        w_mag;
    logic [DW-1:0]      w_len;
    logic               w_bad;
    logic [31:0]        w_nre;
    logic [31:0]        w_nim;
    logic [NW-1:0]      w_num_re;
    logic [NW-1:0]      w_num_im;
    logic [CW-1:0]      w_top;

    // exact cross sums, floor shift
    assign w_sre = (66'(i_s1.p0) - 66'(i_s1.p1)) >>> FRAC_BITS;
    assign w_sim = (66'(i_s1.p2) + 66'(i_s1.p3)) >>> FRAC_BITS;

    // squared magnitude in q format
    assign w_mag = 64'(i_s1.p0) + 64'(i_s1.p1);
    assign w_len = DW'(w_mag >> FRAC_BITS);
    assign w_bad = (w_len == '0) || (w_len < DW'(i_epsilon));

    // numerator magnitudes
    assign w_nre = i_s1.ar[31] ? 32'(-33'(i_s1.ar)) : 32'(i_s1.ar);
    assign w_nim = i_s1.ai[31] ? 32'(-33'(i_s1.ai)) : 32'(i_s1.ai);
    assign w_num_re = {w_nre, FRAC_BITS'(0)};
    assign w_num_im = {w_nim, FRAC_BITS'(0)};
    assign w_top = CW'(w_len) << QW;

    always_comb begin
        n_dv         = '0;
        n_dv.valid   = i_s1.valid;
        n_dv.dir_re  = i_s1.dir_re;
        n_dv.dir_im  = i_s1.dir_im;
        n_dv.dir_ok  = i_s1.dir_ok;
        n_dv.rem_re  = w_num_re;
        n_dv.rem_im  = w_num_im;
        n_dv.dsh     = CW'(w_len) << (QW - 1);
        n_dv.neg_re  = i_s1.ar[31];
        n_dv.neg_im  = !i_s1.ai[31] && (i_s1.ai != '0);
        n_dv.ovf_re  = CW'(w_num_re) >= w_top;
        n_dv.ovf_im  = CW'(w_num_im) >= w_top;
        priority if (i_s1.is_prod) begin
            n_dv.dir_re = sat32(w_sre);
            n_dv.dir_im = sat32(w_sim);
        end else if (i_s1.is_inv) begin
            if (w_bad) begin
                n_dv.dir_re = i_s1.ar;
                n_dv.dir_im = i_s1.ai;
                n_dv.dir_ok = 1'b0;
            end else begin
                n_dv.use_div = 1'b1;
                n_dv.dir_ok  = 1'b1;
            end
        end else begin
            n_dv.use_div = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.valid <= 1'b0;
        end else begin
            r_dv.valid <= n_dv.valid;
        end
        r_dv.use_div <= n_dv.use_div;
        r_dv.dir_re  <= n_dv.dir_re;
        r_dv.dir_im  <= n_dv.dir_im;
        r_dv.dir_ok  <= n_dv.dir_ok;
        r_dv.rem_re  <= n_dv.rem_re;
        r_dv.rem_im  <= n_dv.rem_im;
        r_dv.dsh     <= n_dv.dsh;
        r_dv.q_re    <= n_dv.q_re;
        r_dv.q_im    <= n_dv.q_im;
        r_dv.neg_re  <= n_dv.neg_re;
        r_dv.neg_im  <= n_dv.neg_im;
        r_dv.ovf_re  <= n_dv.ovf_re;
        r_dv.ovf_im  <= n_dv.ovf_im;
    end

    assign o_dv = r_dv;
endmodule
`default_nettype wire

>>> hw/rtl/cau_div_step.sv
// one restoring division stage, one quotient bit for each part
`default_nettype none
module cau_div_step (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  cau_pkg::t_dv i_dv,
    output cau_pkg::t_dv o_dv
);
    import cau_pkg::*;

    t_dv r_dv;
    t_dv n_dv;
    logic [CW-1:0] w_ext_re;
    logic [CW-1:0] w_ext_im;
    logic          w_ge_re;
    logic          w_ge_im;

    // trial subtract of the shifted divisor
    assign w_ext_re = CW'(i_dv.rem_re);
    assign w_ext_im = CW'(i_dv.rem_im);
    assign w_ge_re  = w_ext_re >= i_dv.dsh;
    assign w_ge_im  = w_ext_im >= i_dv.dsh;

    always_comb begin
        n_dv        = i_dv;
        n_dv.rem_re = w_ge_re ? NW'(w_ext_re - i_dv.dsh) : i_dv.rem_re;
        n_dv.rem_im = w_ge_im ? NW'(w_ext_im - i_dv.dsh) : i_dv.rem_im;
        n_dv.q_re   = {i_dv.q_re[QW-2:0], w_ge_re};
        n_dv.q_im   = {i_dv.q_im[QW-2:0], w_ge_im};
        n_dv.dsh    = i_dv.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.valid <= 1'b0;
        end else begin
            r_dv.valid <= n_dv.valid;
        end
        r_dv.use_div <= n_dv.use_div;
        r_dv.dir_re  <= n_dv.dir_re;
        r_dv.dir_im  <= n_dv.dir_im;
        r_dv.dir_ok  <= n_dv.dir_ok;
        r_dv.rem_re  <= n_dv.rem_re;
        r_dv.rem_im  <= n_dv.rem_im;
        r_dv.dsh     <= n_dv.dsh;
        r_dv.q_re    <= n_dv.q_re;
        r_dv.q_im    <= n_dv.q_im;
        r_dv.neg_re  <= n_dv.neg_re;
        r_dv.neg_im  <= n_dv.neg_im;
        r_dv.ovf_re  <= n_dv.ovf_re;
        r_dv.ovf_im  <= n_dv.ovf_im;
    end

    assign o_dv = r_dv;
endmodule
`default_nettype wire

>>> hw/rtl/complex_arith_unit.sv
// complex arithmetic unit top level
//
// Fully pipelined Q16.16 complex ALU: one transaction may be started every
// clock cycle and busy is low at all times except in reset and the first
// cycle after it. Every transaction
// yields exactly one result, shown with o_valid for one cycle, once it has
// passed the input register, one multiplier stage, one rescale stage, 31
// divider stages of one quotient bit each and the output register.
// Results leave in the order of their
// transactions and cannot be held off. Epsilon may be written at any time
// (cfg ready stays high) but takes effect on transactions still in flight,
// so write it only while the pipeline is empty.
`default_nettype none
`include "complex_arith_unit_assert.svh"
module complex_arith_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_a_re,
    input  wire logic signed [31:0] i_a_im,
    input  wire logic signed [31:0] i_b_re,
    input  wire logic signed [31:0] i_b_im,
    output logic                    o_valid,
    output logic signed [31:0]      o_res_re,
    output logic signed [31:0]      o_res_im,
    output logic                    o_ok,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [30:0]        i_cfg_data
);
    import cau_pkg::*;

    localparam int LATENCY = DIV_STEPS + 4;

    logic        r_busy;
    logic [30:0] r_epsilon;
    logic        r_valid;
    logic signed [31:0] r_res_re;
    logic signed [31:0] r_res_im;
    logic        r_ok;
    logic signed [31:0] n_res_re;
    logic signed [31:0] n_res_im;
    logic        w_take;
    t_s1         w_s1;
    t_dv         w_dv [0:DIV_STEPS];

    assign w_take = start && !r_busy;

    // busy in reset and until the first clock edge out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // epsilon register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= 31'd1;
        end else if (i_cfg_valid) begin
            r_epsilon <= i_cfg_data;
        end
    end

    cau_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_take),
        .i_operation (i_operation),
        .i_a_re      (i_a_re),
        .i_a_im      (i_a_im),
        .i_b_re      (i_b_re),
        .i_b_im      (i_b_im),
        .i_epsilon   (r_epsilon),
        .o_s1        (w_s1)
    );

    cau_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (w_s1),
        .i_epsilon (r_epsilon),
        .o_dv      (w_dv[0])
    );

    // divider chain
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_dv    (w_dv[g]),
            .o_dv    (w_dv[g+1])
        );
    end

    // final sign and saturation of the quotients
    always_comb begin
        n_res_re = w_dv[DIV_STEPS].dir_re;
        n_res_im = w_dv[DIV_STEPS].dir_im;
        if (w_dv[DIV_STEPS].use_div) begin
            if (w_dv[DIV_STEPS].ovf_re) begin
                n_res_re = w_dv[DIV_STEPS].neg_re ? SAT_MIN[31:0] : SAT_MAX[31:0];
            end else begin
                n_res_re = w_dv[DIV_STEPS].neg_re ? -32'(w_dv[DIV_STEPS].q_re)
                                                  : 32'(w_dv[DIV_STEPS].q_re);
            end
            if (w_dv[DIV_STEPS].ovf_im) begin
                n_res_im = w_dv[DIV_STEPS].neg_im ? SAT_MIN[31:0] : SAT_MAX[31:0];
            end else begin
                n_res_im = w_dv[DIV_STEPS].neg_im ? -32'(w_dv[DIV_STEPS].q_im)
                                                  : 32'(w_dv[DIV_STEPS].q_im);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dv[DIV_STEPS].valid;
        end
        r_res_re <= n_res_re;
        r_res_im <= n_res_im;
        r_ok     <= w_dv[DIV_STEPS].dir_ok;
    end

    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_res_re    = r_res_re;
    assign o_res_im    = r_res_im;
    assign o_ok        = r_ok;

    // fixed latency from start to result
    `CAU_ASSERT_NOW(a_latency, 1'b1, r_valid == $past(w_take, LATENCY))
    // a successful inverse always reports ok
    `CAU_ASSERT_NEXT(a_inv_ok, w_dv[DIV_STEPS].valid && w_dv[DIV_STEPS].use_div, r_ok)
    // a positive inverse part never comes out negative
    `CAU_ASSERT_NEXT(a_inv_sign,
        w_dv[DIV_STEPS].valid && w_dv[DIV_STEPS].use_div && !w_dv[DIV_STEPS].neg_re,
        !r_res_re[31])
endmodule
`default_nettype wire

>>> test/complex_arith_unit_test.sv
// testbench for the complex arithmetic unit: directed and random operations checked against a local predictor
`default_nettype none
module complex_arith_unit_test;
    import cau_pkg::*;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               ok;
    } t_alu_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_operation;
    logic signed [31:0] i_a_re;
    logic signed [31:0] i_a_im;
    logic signed [31:0] i_b_re;
    logic signed [31:0] i_b_im;
    logic               o_valid;
    logic signed [31:0] o_res_re;
    logic signed [31:0] o_res_im;
    logic               o_ok;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [30:0]        i_cfg_data;

    // predictor copy of the threshold register
    logic [30:0]        eps_model;
    t_alu_result        pending_results[$];
    int                 error_count;

    complex_arith_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_a_re      (i_a_re),
        .i_a_im      (i_a_im),
        .i_b_re      (i_b_re),
        .i_b_im      (i_b_im),
        .o_valid     (o_valid),
        .o_res_re    (o_res_re),
        .o_res_im    (o_res_im),
        .o_ok        (o_ok),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #400000;
        $display("complex_arith_unit_test NOT OK");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        logic signed [31:0] r;
        if (v > 128'sh7fffffff) begin
            r = 32'sh7fffffff;
        end else if (v < -128'sh80000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // expected result of one operation
    function automatic t_alu_result predict_alu(input logic [2:0] op,
            input logic signed [31:0] ar, input logic signed [31:0] ai,
            input logic signed [31:0] br, input logic signed [31:0] bi);
        logic signed [127:0] xr, xi, yr, yi, rr, ri, mag, lq, dr, di;
        t_alu_result res;
        xr = 128'(ar); xi = 128'(ai); yr = 128'(br); yi = 128'(bi);
        rr = '0; ri = '0;
        res.ok = 1'b1;
        case (op)
            OP_SUM: begin
                rr = xr + yr;
                ri = xi + yi;
            end
            OP_PROD: begin
                // arithmetic shift floors the exact cross sums
                rr = (xr * yr - xi * yi) >>> FRAC_BITS;
                ri = (xr * yi + xi * yr) >>> FRAC_BITS;
            end
            OP_CONJ: begin
                rr = xr;
                ri = -xi;
            end
            OP_NEG: begin
                rr = -xr;
                ri = -xi;
            end
            OP_INV: begin
                mag = xr * xr + xi * xi;
                lq = mag >>> FRAC_BITS;
                if (lq == 0 || lq < $signed({97'd0, eps_model})) begin
                    res.ok = 1'b0;
                    rr = xr;
                    ri = xi;
                end else begin
                    // signed division truncates toward zero
                    rr = (xr <<< FRAC_BITS) / lq;
                    ri = ((-xi) <<< FRAC_BITS) / lq;
                end
            end
            OP_CMP: begin
                dr = xr - yr;
                di = xi - yi;
                if (dr < 0) dr = -dr;
                if (di < 0) di = -di;
                res.ok = (dr < $signed({97'd0, eps_model}))
                      && (di < $signed({97'd0, eps_model}));
            end
            default: begin
                res.ok = 1'b0;
            end
        endcase
        res.re = clamp32(rr);
        res.im = clamp32(ri);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // result checker
    initial begin
        t_alu_result exp_res;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_res_re !== exp_res.re)
                        report_mismatch($sformatf("res_re got %h want %h", o_res_re, exp_res.re));
                    if (o_res_im !== exp_res.im)
                        report_mismatch($sformatf("res_im got %h want %h", o_res_im, exp_res.im));
                    if (o_ok !== exp_res.ok)
                        report_mismatch($sformatf("ok got %b want %b", o_ok, exp_res.ok));
                end
            end
        end
    end

    // one transaction, preceded by a random gap when allow_gap is set
    task automatic send_op(input logic [2:0] op, input logic signed [31:0] ar,
            input logic signed [31:0] ai, input logic signed [31:0] br,
            input logic signed [31:0] bi, input bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17)) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_a_re      <= ar;
        i_a_im      <= ai;
        i_b_re      <= br;
        i_b_im      <= bi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_alu(op, ar, ai, br, bi));
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // threshold write, only with the pipeline empty
    task automatic write_epsilon(input logic [30:0] value);
        drain_pipe();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        eps_model = value;
    endtask

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            3: v = $signed($urandom_range(0, 32'h3ff)) - 32'sh200;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        send_op(OP_SUM, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_op(OP_SUM, 32'sh00010000, -32'sh00020000, 32'sh00008000, 32'sh0);
        send_op(OP_PROD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_op(OP_PROD, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_op(OP_PROD, -32'sh1, 32'sh0, 32'sh1, 32'sh0);
        send_op(OP_PROD, 32'sh00018000, 32'sh00010000, -32'sh00020000, 32'sh00004000);
        send_op(OP_CONJ, 32'sh12345678, 32'sh80000000, 32'sh0, 32'sh0);
        send_op(OP_NEG, 32'sh80000000, 32'sh80000000, 32'sh0, 32'sh0);
        send_op(OP_NEG, 32'sh7fffffff, -32'sh1, 32'sh0, 32'sh0);
        send_op(OP_INV, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
        send_op(OP_INV, 32'sh00000100, 32'sh0, 32'sh0, 32'sh0);
        send_op(OP_INV, 32'sh00010000, 32'sh00010000, 32'sh0, 32'sh0);
        send_op(OP_INV, 32'sh80000000, 32'sh80000000, 32'sh0, 32'sh0);
        send_op(OP_INV, 32'sh00000200, -32'sh00000010, 32'sh0, 32'sh0);
        send_op(OP_CMP, 32'sh10, 32'sh10, 32'sh10, 32'sh10);
        send_op(OP_CMP, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_op(3'd6, 32'sh1, 32'sh1, 32'sh1, 32'sh1);
        send_op(3'd7, 32'sh80000000, 32'sh7fffffff, 32'sh1, 32'sh1);
    endtask

    // threshold extremes: zero, maximum, and a mid value near operand differences
    task automatic test_epsilon_extremes();
        write_epsilon(31'd0);
        send_op(OP_INV, 32'sh00000100, 32'sh0, 32'sh0, 32'sh0);
        send_op(OP_CMP, 32'sh5, 32'sh5, 32'sh5, 32'sh5);
        write_epsilon(31'h7fffffff);
        send_op(OP_INV, 32'sh80000000, 32'sh80000000, 32'sh0, 32'sh0);
        send_op(OP_INV, 32'sh7fffffff, 32'sh7fffffff, 32'sh0, 32'sh0);
        send_op(OP_CMP, 32'sh7fffffff, 32'sh0, 32'sh0, 32'sh0);
        send_op(OP_CMP, 32'sh40000000, 32'shc0000001, 32'sh0, 32'sh0);
        write_epsilon(31'h00000100);
        send_op(OP_CMP, 32'sh100, 32'sh0, 32'sh0, 32'shff);
        send_op(OP_CMP, 32'sh0, 32'shff, 32'sh0, 32'sh0);
    endtask

    // random operations over a few threshold settings, back to back stretches included
    task automatic test_random();
        logic signed [31:0] ar, ai;
        logic [30:0] eps_pick;
        bit burst;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: eps_pick = 31'd1;
                1: eps_pick = 31'($urandom_range(0, 31'h3ffff));
                2: eps_pick = 31'h7fffffff;
                3: eps_pick = 31'($urandom);
                default: eps_pick = 31'($urandom_range(0, 31'h3ff));
            endcase
            write_epsilon(eps_pick);
            burst = 1'b0;
            for (int n = 0; n < 86; n++) begin
                if (n % 20 == 0) burst = $urandom_range(0, 1);
                ar = rand_word();
                ai = rand_word();
                if ($urandom_range(0, 3) == 0) begin
                    // near-equal operands exercise the comparison threshold
                    send_op(OP_CMP, ar, ai,
                            ar + ($signed({1'b0, eps_pick}) >>> $urandom_range(0, 4))
                            - $signed($urandom_range(0, 3)), ai - $signed($urandom_range(0, 7)),
                            !burst);
                end else begin
                    send_op(3'($urandom_range(0, 7)), ar, ai, rand_word(), rand_word(),
                            !burst);
                end
            end
        end
        drain_pipe();
    endtask

    initial begin
        error_count  = 0;
        eps_model    = 31'd1;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = '0;
        i_a_re       = '0;
        i_a_im       = '0;
        i_b_re       = '0;
        i_b_im       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_epsilon_extremes();
        test_random();
        if (error_count == 0) begin
            $display("complex_arith_unit_test OK");
        end else begin
            $display("complex_arith_unit_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
